// ===== rtl/qkd_pkg.sv =====
// Shared constants, payload types and helpers for the quad knob decoder.
// No dependencies; every other file imports this package.
package qkd_pkg;

    localparam int KNOB_COUNT  = 4;   // knobs decoded (1..8)
    localparam int COUNT_WIDTH = 8;   // bits of each knob count (2..16)

    localparam int IN_KNOBS    = 4;   // knobs carried by the input item
    localparam int VALUE_W     = 8;   // width of a reported value
    localparam int MAX_W       = 8;   // width of a limit register
    localparam int CFG_COUNT   = 4;   // limit registers
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int APB_DW      = 32;

    localparam int CMP_W = (COUNT_WIDTH > MAX_W) ? COUNT_WIDTH : MAX_W;
    localparam int EXT_W = (COUNT_WIDTH > VALUE_W) ? COUNT_WIDTH : VALUE_W;

    localparam logic [MAX_W-1:0] MAX_RESET = MAX_W'(15);

    // (B,A) pair codes
    localparam logic [1:0] PAIR_00 = 2'b00;
    localparam logic [1:0] PAIR_01 = 2'b01;
    localparam logic [1:0] PAIR_10 = 2'b10;
    localparam logic [1:0] PAIR_11 = 2'b11;

    typedef struct packed {
        logic [IN_KNOBS-1:0] line_a;
        logic [IN_KNOBS-1:0] line_b;
        logic [IN_KNOBS-1:0] switch_n;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0]  value0;
        logic [VALUE_W-1:0]  value1;
        logic [VALUE_W-1:0]  value2;
        logic [VALUE_W-1:0]  value3;
        logic [IN_KNOBS-1:0] pressed;
    } t_out_item;

    typedef logic [CFG_COUNT-1:0][MAX_W-1:0] t_max_arr;

    // Count to reported value: zero-extend or keep the low bits.
    function automatic logic [VALUE_W-1:0] f_to_value(input logic [COUNT_WIDTH-1:0] cnt);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(cnt);
        return ext[VALUE_W-1:0];
    endfunction

endpackage

// ===== rtl/qkd_cfg.sv =====
// Limit registers of the quad knob decoder behind an APB-style port.
// Depends on qkd_pkg.
module qkd_cfg
    import qkd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready,
    output t_max_arr              o_max
);

    t_max_arr             r_max;
    logic [CFG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx    = paddr[CFG_ADDR_W-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign prdata = APB_DW'(r_max[idx]);
    assign o_max  = r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CFG_COUNT; k++) begin
                r_max[k] <= MAX_RESET;
            end
        end else if (wr_en) begin
            r_max[idx] <= pwdata[MAX_W-1:0];
        end
    end

endmodule

// ===== rtl/qkd_knob.sv =====
// Quadrature step decode and saturating up/down update for one knob.
// Depends on qkd_pkg.
module qkd_knob
    import qkd_pkg::*;
(
    input  logic [COUNT_WIDTH-1:0] i_count,
    input  logic [MAX_W-1:0]       i_limit,
    input  logic [1:0]             i_was,
    input  logic [1:0]             i_now,
    output logic [COUNT_WIDTH-1:0] o_count
);

    logic up, down, room;

    assign up   = ((i_was == PAIR_00) && (i_now == PAIR_01)) ||
                  ((i_was == PAIR_11) && (i_now == PAIR_10));
    assign down = ((i_was == PAIR_01) && (i_now == PAIR_00)) ||
                  ((i_was == PAIR_10) && (i_now == PAIR_11));
    // stop at the limit and at the all-ones count
    assign room = (CMP_W'(i_count) < CMP_W'(i_limit)) && (i_count != '1);

    always_comb begin
        o_count = i_count;
        if (up && room) begin
            o_count = i_count + COUNT_WIDTH'(1);
        end else if (down && (i_count != '0)) begin
            o_count = i_count - COUNT_WIDTH'(1);
        end
    end

endmodule

// ===== rtl/quad_knob_decoder_top.sv =====
// Quad knob decoder: accepted items pass the input register, then the result register.
// Throughput: one item per cycle unless the receiver stalls; input and result registers
// part the two sides; the per-knob decode is a single short compare/increment path.
// Reset (synchronous, active low) empties both registers, clears counts, prior pairs
// and the primed flag, and sets every limit register to 15.
// Depends on qkd_pkg, qkd_cfg, qkd_knob.
module quad_knob_decoder_top
    import qkd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input item channel
    input  logic                  i_valid,
    input  t_in_item              i_data,
    output logic                  o_stall,
    // result item channel
    output logic                  o_valid,
    output t_out_item             o_data,
    input  logic                  i_stall,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    t_max_arr cfg_max;

    qkd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_max   (cfg_max)
    );

    // ---------------------------------------------------------------
    // Handshake: the input register takes an item whenever it is empty
    // or drains this cycle; it drains when the result register is free.
    // ---------------------------------------------------------------
    logic      r_in_valid, n_in_valid;
    t_in_item  r_in;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;
    logic      out_free, proc, in_acc;

    assign out_free = !r_out_valid || !i_stall;
    assign proc     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_acc   = i_valid && !o_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_acc) begin
            n_in_valid = 1'b1;
        end else if (proc) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (proc) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Knob state and per-knob decode
    // ---------------------------------------------------------------
    logic [KNOB_COUNT-1:0][1:0]             r_prior;
    logic                                   r_primed;
    logic [KNOB_COUNT-1:0][COUNT_WIDTH-1:0] r_count, n_count, knob_next;
    logic [KNOB_COUNT-1:0][1:0]             now_ab;
    logic [KNOB_COUNT-1:0][MAX_W-1:0]       limit;

    for (genvar k = 0; k < KNOB_COUNT; k++) begin : g_knob
        // knobs past the input width see idle lines, those past the limit registers the reset limit
        if (k < IN_KNOBS) begin : g_pin
            assign now_ab[k] = {r_in.line_b[k], r_in.line_a[k]};
        end else begin : g_nopin
            assign now_ab[k] = PAIR_00;
        end
        if (k < CFG_COUNT) begin : g_lim
            assign limit[k] = cfg_max[k];
        end else begin : g_nolim
            assign limit[k] = MAX_RESET;
        end

        qkd_knob u_knob (
            .i_count (r_count[k]),
            .i_limit (limit[k]),
            .i_was   (r_prior[k]),
            .i_now   (now_ab[k]),
            .o_count (knob_next[k])
        );

        // first sample after reset only primes the prior pair
        assign n_count[k] = r_primed ? knob_next[k] : r_count[k];
    end

    // ---------------------------------------------------------------
    // Result assembly: four reported values and pressed flags
    // ---------------------------------------------------------------
    logic [IN_KNOBS-1:0][VALUE_W-1:0] vals;

    for (genvar k = 0; k < IN_KNOBS; k++) begin : g_val
        if (k < KNOB_COUNT) begin : g_has
            assign vals[k] = f_to_value(n_count[k]);
        end else begin : g_none
            assign vals[k] = '0;
        end
    end

    always_comb begin
        n_out.value0  = vals[0];
        n_out.value1  = vals[1];
        n_out.value2  = vals[2];
        n_out.value3  = vals[3];
        n_out.pressed = ~r_in.switch_n;
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_primed    <= 1'b0;
            r_prior     <= '0;
            r_count     <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            // advance knob state once per processed item
            if (proc) begin
                r_primed <= 1'b1;
                r_prior  <= now_ab;
                r_count  <= n_count;
            end
        end
    end

    // payload registers: input loads on accept, result on processing; both hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_data;
        end
        if (proc) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== rtl/qkd_checker.sv =====
// Port-level checks for the quad knob decoder, bound to the top level.
// Depends on qkd_pkg and quad_knob_decoder_top.
module qkd_checker
    import qkd_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_stall,
    input logic                  o_valid,
    input t_out_item             o_data,
    input logic                  i_stall
);

    logic                             r_seen;
    logic [IN_KNOBS-1:0][VALUE_W-1:0] r_prev;
    logic [IN_KNOBS-1:0][VALUE_W-1:0] cur;
    logic [IN_KNOBS-1:0]              step_ok;
    logic                             out_acc;

    assign out_acc = o_valid && !i_stall;
    assign cur     = {o_data.value3, o_data.value2, o_data.value1, o_data.value0};

    for (genvar k = 0; k < IN_KNOBS; k++) begin : g_step
        assign step_ok[k] = (cur[k] == r_prev[k]) ||
                            (cur[k] == r_prev[k] + VALUE_W'(1)) ||
                            (cur[k] == r_prev[k] - VALUE_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (out_acc) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_acc) begin
            r_prev <= cur;
        end
    end

    // a stalled result stays and holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result item changed while stalled");

    // upstream is stalled only while a result is waiting
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with result side free");

    // counts move by at most one step between delivered items
    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_seen |-> (step_ok == '1))
        else $error("knob value jumped by more than one");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind quad_knob_decoder_top qkd_checker u_qkd_checker (.*);

// ===== tb/sv/tb.sv =====
// Testbench for quad_knob_decoder_top: drives (A,B,switch) samples for four knobs,
// predicts counts and pressed flags per item, and checks every result item.
// Depends on qkd_pkg and the quad_knob_decoder_top RTL.
module tb;
    import qkd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int CHUNK       = 50;      // items per idling pattern in random walks
    localparam int HOLD_CYCLES = 300;     // long receiver hold-off

    // Knob moves used to build well-formed quadrature sequences.
    typedef enum logic [1:0] {MV_HOLD, MV_FWD, MV_BACK, MV_JUMP} t_move;

    // Clock, reset and block ports; every input starts at a known value.
    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    t_in_item              i_data  = '0;
    logic                  o_stall;
    logic                  o_valid;
    t_out_item             o_data;
    logic                  i_stall = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [APB_DW-1:0]     pwdata  = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    // Predicted state of the decoder.
    logic [COUNT_WIDTH-1:0] knob_cnt  [IN_KNOBS];
    logic [MAX_W-1:0]       knob_lim  [IN_KNOBS];
    logic [1:0]             last_pair [IN_KNOBS];
    logic                   primed;

    // Current line levels per knob, as the stimulus sees them.
    logic [1:0] stim_pair [IN_KNOBS];

    t_out_item knob_readouts [$];   // predicted result items, oldest first

    int fail_count  = 0;
    int cycle_count = 0;
    bit tx_calm     = 1'b0;         // sender idles between items unless set
    bit rx_calm     = 1'b0;         // receiver stalls between items unless set
    int rx_wait     = 0;
    int rx_hold     = 0;

    quad_knob_decoder_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // Bound the run; a hang or a lost item ends here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    initial begin
        for (int k = 0; k < IN_KNOBS; k++) begin
            knob_cnt[k]  = '0;
            knob_lim[k]  = MAX_RESET;
            last_pair[k] = PAIR_00;
            stim_pair[k] = PAIR_00;
        end
        primed = 1'b0;
    end

    // Advance the predicted knob state by one sample and return the result item.
    function automatic t_out_item advance_knobs(input t_in_item s);
        t_out_item              r;
        logic [1:0]             was;
        logic [1:0]             now;
        logic [COUNT_WIDTH-1:0] c;
        logic                   up;
        logic                   down;
        for (int k = 0; k < IN_KNOBS; k++) begin
            now  = {s.line_b[k], s.line_a[k]};
            was  = last_pair[k];
            up   = (was == PAIR_00 && now == PAIR_01) || (was == PAIR_11 && now == PAIR_10);
            down = (was == PAIR_01 && now == PAIR_00) || (was == PAIR_10 && now == PAIR_11);
            c    = knob_cnt[k];
            // The first sample after reset only records the line levels.
            if (primed) begin
                // Saturate at the knob limit and at the top of the count width.
                if (up && CMP_W'(c) < CMP_W'(knob_lim[k]) && c != '1)
                    c = c + COUNT_WIDTH'(1);
                else if (down && c != '0)
                    c = c - COUNT_WIDTH'(1);
            end
            knob_cnt[k]  = c;
            last_pair[k] = now;
        end
        primed    = 1'b1;
        r.value0  = VALUE_W'(knob_cnt[0]);
        r.value1  = VALUE_W'(knob_cnt[1]);
        r.value2  = VALUE_W'(knob_cnt[2]);
        r.value3  = VALUE_W'(knob_cnt[3]);
        r.pressed = ~s.switch_n;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare each result item taken from the block with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (knob_readouts.size() == 0) begin
                $error("result item with no prediction waiting");
                fail_count++;
            end else begin
                want = knob_readouts.pop_front();
                check_field("value0", want.value0, o_data.value0);
                check_field("value1", want.value1, o_data.value1);
                check_field("value2", want.value2, o_data.value2);
                check_field("value3", want.value3, o_data.value3);
                check_field("pressed", want.pressed, o_data.pressed);
            end
        end
    end

    // Receiver: stall a drawn number of cycles before each result item, and
    // hold off completely while a long hold-off is pending.
    always @(posedge i_clk) begin
        if (rx_hold > 0)
            rx_hold--;
        if (o_valid && !i_stall)
            rx_wait = rx_calm ? 0 : $urandom_range(0, 9);
        else if (rx_wait > 0)
            rx_wait--;
        i_stall <= (rx_wait > 0) || (rx_hold > 0);
    end

    // ------------------------------------------------------------------
    // Sender and register access
    // ------------------------------------------------------------------

    // Offer one sample item; predict its result at the edge that takes it.
    task automatic send_item(input t_in_item it);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        for (int k = 0; k < IN_KNOBS; k++)
            stim_pair[k] = {it.line_b[k], it.line_a[k]};
        // Hold the item until an edge finds the block not stalling.
        do @(posedge i_clk); while (o_stall);
        knob_readouts.push_back(advance_knobs(it));
    endtask

    // Drive every knob to the same pair.
    task automatic drive_pairs(input logic [1:0] p, input logic [IN_KNOBS-1:0] sw);
        t_in_item it;
        it.line_a   = {IN_KNOBS{p[0]}};
        it.line_b   = {IN_KNOBS{p[1]}};
        it.switch_n = sw;
        send_item(it);
    endtask

    // Drop valid and wait until every predicted result item has come back.
    task automatic wait_drain();
        i_valid <= 1'b0;
        while (knob_readouts.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic read_limit(input int idx, input logic [MAX_W-1:0] want);
        string name;
        name = $sformatf("knob%0d_max", idx);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= CFG_ADDR_W'(4 * idx);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field(name, want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write one limit register while the block is idle, then read it back.
    task automatic write_limit(input int idx, input logic [MAX_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= CFG_ADDR_W'(4 * idx);
        pwdata  <= APB_DW'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        knob_lim[idx] = val;
        read_limit(idx, val);
    endtask

    task automatic write_limits(input logic [MAX_W-1:0] l0, input logic [MAX_W-1:0] l1,
                                input logic [MAX_W-1:0] l2, input logic [MAX_W-1:0] l3);
        wait_drain();
        write_limit(0, l0);
        write_limit(1, l1);
        write_limit(2, l2);
        write_limit(3, l3);
    endtask

    function automatic logic [1:0] move_pair(input logic [1:0] p, input t_move m);
        case (m)
            MV_FWD: begin
                case (p)
                    PAIR_00: return PAIR_01;
                    PAIR_01: return PAIR_11;
                    PAIR_11: return PAIR_10;
                    default: return PAIR_00;
                endcase
            end
            MV_BACK: begin
                case (p)
                    PAIR_00: return PAIR_10;
                    PAIR_10: return PAIR_11;
                    PAIR_11: return PAIR_01;
                    default: return PAIR_00;
                endcase
            end
            MV_JUMP: return ~p;     // two-bit jump: 00<->11, 01<->10
            default: return p;
        endcase
    endfunction

    // Random walk of all knobs: mostly single quadrature steps biased by fwd/back
    // percentages, a few two-bit jumps, and now and then a fully random sample.
    task automatic run_walk(input int n, input int fwd, input int back);
        t_in_item   it;
        t_move      m;
        logic [1:0] p;
        int         r;
        for (int i = 0; i < n; i++) begin
            // Switch between idling and back-to-back stretches every chunk.
            if (i % CHUNK == 0) begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 99) < 3) begin
                it.line_a = IN_KNOBS'($urandom_range(0, 15));
                it.line_b = IN_KNOBS'($urandom_range(0, 15));
            end else begin
                for (int k = 0; k < IN_KNOBS; k++) begin
                    r = $urandom_range(0, 99);
                    if (r < fwd)
                        m = MV_FWD;
                    else if (r < fwd + back)
                        m = MV_BACK;
                    else if (r < fwd + back + 5)
                        m = MV_JUMP;
                    else
                        m = MV_HOLD;
                    p = move_pair(stim_pair[k], m);
                    it.line_a[k] = p[0];
                    it.line_b[k] = p[1];
                end
            end
            it.switch_n = IN_KNOBS'($urandom_range(0, 15));
            send_item(it);
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_limit_reset();
        for (int k = 0; k < CFG_COUNT; k++)
            read_limit(k, MAX_RESET);
    endtask

    // First sample only primes the pairs; then a down step at zero stays at zero.
    task automatic test_first_sample();
        drive_pairs(PAIR_01, 4'h0);
        drive_pairs(PAIR_00, 4'hF);
    endtask

    // Forward rotation: 00->01 and 11->10 count up.
    task automatic test_count_up();
        drive_pairs(PAIR_01, 4'hA);
        drive_pairs(PAIR_11, 4'h5);
        drive_pairs(PAIR_10, 4'hA);
        drive_pairs(PAIR_00, 4'h5);
        drive_pairs(PAIR_01, 4'hA);
        drive_pairs(PAIR_11, 4'h5);
        drive_pairs(PAIR_10, 4'hA);
    endtask

    // Reverse rotation: 10->11 and 01->00 count down.
    task automatic test_count_down();
        drive_pairs(PAIR_11, 4'h3);
        drive_pairs(PAIR_01, 4'hC);
        drive_pairs(PAIR_00, 4'h3);
        drive_pairs(PAIR_10, 4'hC);
        drive_pairs(PAIR_11, 4'h3);
    endtask

    // Two-bit jumps leave every count alone.
    task automatic test_two_bit_jumps();
        drive_pairs(PAIR_00, 4'h6);
        drive_pairs(PAIR_11, 4'h9);
        drive_pairs(PAIR_01, 4'h6);
        drive_pairs(PAIR_10, 4'h9);
        drive_pairs(PAIR_01, 4'h0);
    endtask

    // A zero limit blocks counting up; the other knobs take the extremes.
    task automatic test_zero_limit();
        write_limits(8'd0, 8'd1, 8'd255, 8'd15);
        drive_pairs(PAIR_00, 4'hF);
        drive_pairs(PAIR_01, 4'h0);
        drive_pairs(PAIR_11, 4'hF);
        drive_pairs(PAIR_10, 4'h0);
    endtask

    task automatic test_small_limits();
        for (int round = 0; round < 2; round++) begin
            write_limits(MAX_W'($urandom_range(0, 20)), MAX_W'($urandom_range(0, 20)),
                         MAX_W'($urandom_range(0, 20)), MAX_W'($urandom_range(0, 20)));
            run_walk(200, 45, 35);
        end
    endtask

    // Drive the counts toward the top of the count width.
    task automatic test_full_range();
        write_limits(8'd255, 8'd255, 8'd255, 8'd255);
        run_walk(560, 95, 2);
    endtask

    // Limits lowered below the counts: no counting up, counting down still works.
    task automatic test_lowered_limit();
        write_limits(8'd3, 8'd0, 8'd100, 8'd200);
        run_walk(250, 20, 60);
    endtask

    // Hold the receiver off long enough that the block fills and stalls its input.
    task automatic test_backpressure();
        wait_drain();
        rx_hold = HOLD_CYCLES;
        tx_calm = 1'b1;
        for (int i = 0; i < 60; i++)
            drive_pairs(move_pair(stim_pair[0], MV_FWD), IN_KNOBS'($urandom_range(0, 15)));
        tx_calm = 1'b0;
    endtask

    // Pause the sender until every result has come back, then carry on.
    task automatic test_sender_pause();
        run_walk(50, 40, 40);
        wait_drain();
        run_walk(50, 40, 40);
    endtask

    task automatic test_mixed_limits();
        write_limits(8'd1, 8'd255, 8'd0, MAX_W'($urandom_range(0, 255)));
        run_walk(300, 50, 40);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_limit_reset();
        test_first_sample();
        test_count_up();
        test_count_down();
        test_two_bit_jumps();
        test_zero_limit();
        test_small_limits();
        test_full_range();
        test_lowered_limit();
        test_backpressure();
        test_sender_pause();
        test_mixed_limits();

        // Let the last results out, then allow a few more cycles for strays.
        wait_drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && knob_readouts.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/qkd_pkg.sv
rtl/qkd_cfg.sv
rtl/qkd_knob.sv
rtl/quad_knob_decoder_top.sv
rtl/qkd_checker.sv
tb/sv/tb.sv
